// File: rtl/core/dht_pkg.sv
// shared widths, status codes and register indexes of the double hash table
package dht_pkg;

	localparam int KEY_W    = 31;
	localparam int ENTRY_W  = KEY_W + 1;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 10;
	localparam int TSIZE_W  = 11;
	localparam int PRIME_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PRIME = 1'b1;

endpackage

// File: rtl/core/dht_mod.sv
// bit-serial remainder unit, one dividend against two divisors at once
module dht_mod #(
	parameter int SW = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dht_pkg::KEY_W-1:0]   dividend,
	input  logic [SW-1:0]               div_a,
	input  logic [dht_pkg::PRIME_W-1:0] div_b,
	output logic                        done,
	output logic [SW-1:0]               rem_a,
	output logic [dht_pkg::PRIME_W-1:0] rem_b
);

	localparam int CW = $clog2(dht_pkg::KEY_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [dht_pkg::KEY_W-1:0]   dvd_q;
	logic [SW-1:0]               da_q;
	logic [dht_pkg::PRIME_W-1:0] db_q;
	logic [SW-1:0]               ra_q;
	logic [dht_pkg::PRIME_W-1:0] rb_q;
	logic [SW:0]                 ta;
	logic [dht_pkg::PRIME_W:0]   tb;
	logic [SW-1:0]               ra_nxt;
	logic [dht_pkg::PRIME_W-1:0] rb_nxt;

	// one restoring step per cycle, msb of the dividend first
	always_comb begin
		ta = {ra_q, dvd_q[dht_pkg::KEY_W-1]};
		tb = {rb_q, dvd_q[dht_pkg::KEY_W-1]};
		if (ta >= {1'b0, da_q}) begin
			ra_nxt = SW'(ta - {1'b0, da_q});
		end else begin
			ra_nxt = SW'(ta);
		end
		if (tb >= {1'b0, db_q}) begin
			rb_nxt = dht_pkg::PRIME_W'(tb - {1'b0, db_q});
		end else begin
			rb_nxt = dht_pkg::PRIME_W'(tb);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(dht_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			da_q  <= div_a;
			db_q  <= div_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[dht_pkg::KEY_W-2:0], 1'b0};
			ra_q  <= ra_nxt;
			rb_q  <= rb_nxt;
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

// File: rtl/core/dht_mem.sv
// slot store: valid mark and key per slot, one port, registered read
module dht_mem #(
	parameter int AW = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               addr,
	input  logic [dht_pkg::ENTRY_W-1:0] wdata,
	output logic [dht_pkg::ENTRY_W-1:0] rdata
);

	logic [dht_pkg::ENTRY_W-1:0] mem [2**AW];
	logic [dht_pkg::ENTRY_W-1:0] rdata_q;

	// write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// read
	always_ff @(posedge clk) begin
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/double_hash_table_core.sv
// each word runs two remainder passes, then one memory read and one check per probe;
// a refused insert goes straight to the result.
// one word in flight at a time; the next word can be taken in the cycle after the result is loaded.
// a result waiting at the output does not hold back the next input word.
// after reset a clearing pass empties every slot;
// no input word is taken during it, configuration writes are.
module double_hash_table_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [dht_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dht_pkg::STATUS_W-1:0]  status,
	output logic [dht_pkg::SLOT_W-1:0]    slot,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dht_pkg::TSIZE_W-1:0]   cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD1  = 3'd2;
	localparam logic [2:0] S_MOD2  = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]                         state_q;
	logic [dht_pkg::TSIZE_W-1:0]        tsize_q;
	logic [dht_pkg::PRIME_W-1:0]        prime_cfg_q;
	logic [dht_pkg::COUNT_W-1:0]        count_q;
	logic [AW-1:0]                      clr_q;
	logic                               op_q;
	logic [dht_pkg::KEY_W-1:0]          key_q;
	logic [SW-1:0]                      size_q;
	logic [dht_pkg::PRIME_W-1:0]        prime_q;
	logic [AW-1:0]                      pos_q;
	logic [AW-1:0]                      step_q;
	logic [SW-1:0]                      cnt_q;
	logic [dht_pkg::STATUS_W-1:0]       res_status_q;
	logic [AW-1:0]                      res_pos_q;
	logic                               out_valid_q;
	logic [dht_pkg::STATUS_W-1:0]       status_q;
	logic [dht_pkg::SLOT_W-1:0]         slot_q;

	logic [SW-1:0]                      size_now;
	logic [dht_pkg::PRIME_W-1:0]        prime_now;
	logic                               refuse;
	logic                               accept;
	logic                               mod_start;
	logic [dht_pkg::KEY_W-1:0]          mod_dvd;
	logic [SW-1:0]                      mod_da;
	logic                               mod_done;
	logic [SW-1:0]                      rem_a;
	logic [dht_pkg::PRIME_W-1:0]        rem_b;
	logic                               mem_we;
	logic [AW-1:0]                      mem_addr;
	logic [dht_pkg::ENTRY_W-1:0]        mem_wdata;
	logic [dht_pkg::ENTRY_W-1:0]        mem_rdata;
	logic                               ent_valid;
	logic [dht_pkg::KEY_W-1:0]          ent_key;
	logic [SW:0]                        pos_sum;
	logic [AW-1:0]                      pos_nxt;
	logic                               last_probe;
	logic                               out_free;

	// configuration port
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q     <= dht_pkg::TSIZE_W'(1024);
			prime_cfg_q <= dht_pkg::PRIME_W'(1021);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dht_pkg::REG_TABLE_SIZE: tsize_q <= cfg_data;
				dht_pkg::REG_STEP_PRIME: prime_cfg_q <= cfg_data[dht_pkg::PRIME_W-1:0];
				default: ;
			endcase
		end
	end

	// effective size and prime, load limit check
	always_comb begin
		if (tsize_q == '0) begin
			size_now = SW'(1);
		end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
			size_now = SW'(TABLE_DEPTH);
		end else begin
			size_now = SW'(tsize_q);
		end
		prime_now = (prime_cfg_q == '0) ? dht_pkg::PRIME_W'(1) : prime_cfg_q;
		refuse    = (op == 1'b0) && (32'({count_q, 1'b0}) >= 32'(size_now));
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// remainder unit: key mod size and key mod prime, then step mod size
	assign mod_start = (accept && !refuse) || (state_q == S_MOD1 && mod_done);
	assign mod_dvd   = (state_q == S_IDLE) ? key
		: dht_pkg::KEY_W'(prime_q - rem_b);
	assign mod_da    = (state_q == S_IDLE) ? size_now : size_q;

	dht_mod #(
		.SW(SW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(mod_dvd),
		.div_a   (mod_da),
		.div_b   (prime_now),
		.done    (mod_done),
		.rem_a   (rem_a),
		.rem_b   (rem_b)
	);

	// slot store access
	assign ent_valid = mem_rdata[dht_pkg::ENTRY_W-1];
	assign ent_key   = mem_rdata[dht_pkg::KEY_W-1:0];
	assign mem_addr  = (state_q == S_CLEAR) ? clr_q : pos_q;
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_CHK && !op_q && !ent_valid);
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, key_q};

	dht_mem #(
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// next probe position, both terms below size
	assign pos_sum    = (SW + 1)'(pos_q) + (SW + 1)'(step_q);
	assign pos_nxt    = (pos_sum >= {1'b0, size_q}) ? AW'(pos_sum - {1'b0, size_q})
		: AW'(pos_sum);
	assign last_probe = (cnt_q == SW'(size_q - 1'b1));
	assign out_free   = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= refuse ? S_DONE : S_MOD1;
					end
				end
				S_MOD1: begin
					if (mod_done) begin
						state_q <= S_MOD2;
					end
				end
				S_MOD2: begin
					if (mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (!op_q && !ent_valid) begin
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (op_q && (!ent_valid || ent_key == key_q)) begin
						state_q <= S_DONE;
					end else if (last_probe) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op;
			key_q        <= key;
			size_q       <= size_now;
			prime_q      <= prime_now;
			res_status_q <= dht_pkg::ST_REFUSED;
			res_pos_q    <= '0;
		end
		if (state_q == S_MOD1 && mod_done) begin
			pos_q <= AW'(rem_a);
		end
		if (state_q == S_MOD2 && mod_done) begin
			step_q <= AW'(rem_a);
			cnt_q  <= '0;
		end
		if (state_q == S_CHK) begin
			if (!op_q && !ent_valid) begin
				res_status_q <= dht_pkg::ST_INSERTED;
				res_pos_q    <= pos_q;
			end else if (op_q && !ent_valid) begin
				res_status_q <= dht_pkg::ST_NOT_FOUND;
			end else if (op_q && ent_key == key_q) begin
				res_status_q <= dht_pkg::ST_FOUND;
				res_pos_q    <= pos_q;
			end else if (last_probe) begin
				res_status_q <= op_q ? dht_pkg::ST_NOT_FOUND : dht_pkg::ST_FULL;
			end else begin
				pos_q <= pos_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			slot_q   <= dht_pkg::SLOT_W'(res_pos_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;

endmodule
